// ===== rtl/srma_pkg.sv =====
// Package for the sparse row merge accumulate unit.
// Holds command and kind codes, the controller state type and the
// controller/datapath command and status structs. No dependencies.
package srma_pkg;

  localparam logic [1:0] CMD_ELEM   = 2'd0;
  localparam logic [1:0] CMD_EMPTY  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [1:0] KIND_ELEM = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // default quiet NaN for an invalid add
  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC00000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_M_RD,
    ST_M_CMP,
    ST_M_ADD,
    ST_M_FIN,
    ST_C_RD,
    ST_C_CMP,
    ST_SWAP,
    ST_BEGIN,
    ST_APPLY,
    ST_E_RD,
    ST_E_OUT,
    ST_E_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic push_old;
    logic push_in;
    logic push_sum;
    logic op_inc;
    logic fadd_start;
    logic swap;
    logic seg_set;
    logic apply_begin;
    logic emit_clear;
    logic load_elem;
    logic load_end;
    logic load_done;
    logic reset_all;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       last;
    logic       seg_open;
    logic       row_open;
    logic       row_diff;
    logic       op_lt;
    logic       col_lt;
    logic       col_eq;
    logic       sum_done;
    logic       oslot;
  } dp_stat_t;

endpackage

// ===== rtl/srma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/srma_fadd.sv =====
// Four-stage IEEE binary32 adder, round to nearest even.
// Stages: align, add, normalize, round. Uses srma_pkg.
module srma_fadd (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] result
);
  import srma_pkg::*;

  logic [3:0] vld;

  logic        s1_spec, s1_sign, s1_sub, s1_zs;
  logic [31:0] s1_spec_val;
  logic [7:0]  s1_e;
  logic [26:0] s1_mb, s1_al;

  logic        s2_spec, s2_sign, s2_zs;
  logic [31:0] s2_spec_val;
  logic [7:0]  s2_e;
  logic [27:0] s2_sum;

  logic        s3_spec, s3_sign, s3_zs, s3_zero;
  logic [31:0] s3_spec_val;
  logic [8:0]  s3_e;
  logic [26:0] s3_m;

  // stage 1 signals
  logic        a_nan, b_nan, a_inf, b_inf, a_gt;
  logic [31:0] big, sml, spec_val;
  logic [7:0]  eb, es, diff;
  logic [23:0] mb, ms;
  logic [26:0] ms27, al, lost_mask;
  logic        spec;

  // stage 3 signals
  logic [4:0]  lz, sh;
  logic [26:0] m_n;
  logic [8:0]  e_n;

  // stage 4 signals
  logic        inc;
  logic [24:0] mr;
  logic [8:0]  e_f;
  logic [22:0] frac;
  logic [31:0] res_n;

  // classify and align the smaller operand
  always_comb begin
    a_nan = (&a[30:23]) && (|a[22:0]);
    b_nan = (&b[30:23]) && (|b[22:0]);
    a_inf = (&a[30:23]) && !(|a[22:0]);
    b_inf = (&b[30:23]) && !(|b[22:0]);
    spec = 1'b1;
    if (a_nan) begin
      spec_val = a | 32'h00400000;
    end else if (b_nan) begin
      spec_val = b | 32'h00400000;
    end else if (a_inf && b_inf && (a[31] != b[31])) begin
      spec_val = QNAN_DEFAULT;
    end else if (a_inf) begin
      spec_val = a;
    end else if (b_inf) begin
      spec_val = b;
    end else begin
      spec_val = 32'h0;
      spec = 1'b0;
    end
    a_gt = a[30:0] >= b[30:0];
    big  = a_gt ? a : b;
    sml  = a_gt ? b : a;
    eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb   = {(big[30:23] != 8'd0), big[22:0]};
    ms   = {(sml[30:23] != 8'd0), sml[22:0]};
    diff = eb - es;
    ms27 = {ms, 3'b000};
    lost_mask = (27'd1 << diff) - 27'd1;
    if (diff >= 8'd27) begin
      al = {26'd0, |ms};
    end else begin
      al = (ms27 >> diff) | {26'd0, |(ms27 & lost_mask)};
    end
  end

  // leading zero count and normalizing shift
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (s2_sum[i]) begin
        lz = 5'(26 - i);
      end
    end
    if (s2_sum[27]) begin
      sh  = 5'd0;
      m_n = {s2_sum[27:2], s2_sum[1] | s2_sum[0]};
      e_n = {1'b0, s2_e} + 9'd1;
    end else begin
      sh  = ({3'b000, lz} < s2_e) ? lz : 5'(s2_e - 8'd1);
      m_n = s2_sum[26:0] << sh;
      e_n = {1'b0, s2_e} - {4'd0, sh};
    end
  end

  // round to nearest even and pack
  always_comb begin
    inc  = s3_m[2] & (s3_m[1] | s3_m[0] | s3_m[3]);
    mr   = {1'b0, s3_m[26:3]} + {24'd0, inc};
    e_f  = mr[24] ? (s3_e + 9'd1) : (mr[23] ? s3_e : 9'd0);
    frac = mr[24] ? mr[23:1] : mr[22:0];
    if (s3_spec) begin
      res_n = s3_spec_val;
    end else if (s3_zero) begin
      res_n = {s3_zs, 31'd0};
    end else if (e_f >= 9'd255) begin
      res_n = {s3_sign, 8'hFF, 23'd0};
    end else begin
      res_n = {s3_sign, e_f[7:0], frac};
    end
  end

  // advance the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 4'd0;
    end else begin
      vld <= {vld[2:0], start};
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_spec     <= spec;
    s1_spec_val <= spec_val;
    s1_sign     <= big[31];
    s1_sub      <= a[31] ^ b[31];
    s1_zs       <= a[31] & b[31];
    s1_e        <= eb;
    s1_mb       <= {mb, 3'b000};
    s1_al       <= al;

    s2_spec     <= s1_spec;
    s2_spec_val <= s1_spec_val;
    s2_sign     <= s1_sign;
    s2_zs       <= s1_zs;
    s2_e        <= s1_e;
    s2_sum      <= s1_sub ? ({1'b0, s1_mb} - {1'b0, s1_al})
                          : ({1'b0, s1_mb} + {1'b0, s1_al});

    s3_spec     <= s2_spec;
    s3_spec_val <= s2_spec_val;
    s3_sign     <= s2_sign;
    s3_zs       <= s2_zs;
    s3_zero     <= (s2_sum == 28'd0);
    s3_e        <= e_n;
    s3_m        <= m_n;

    result      <= res_n;
  end

  assign done = vld[3];

endmodule

// ===== rtl/srma_ctrl.sv =====
// Controller state machine for the sparse row merge accumulate unit.
// Sequences merge, close, emit and finish steps. Uses srma_pkg.
module srma_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  srma_pkg::dp_stat_t stat,
  output srma_pkg::dp_cmd_t  cmd
);
  import srma_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (stat.cmd)
          CMD_ELEM:   state_next = stat.seg_open ? ST_M_RD : ST_BEGIN;
          CMD_EMPTY:  state_next = stat.seg_open ? ST_C_RD : ST_BEGIN;
          CMD_FINISH: state_next = stat.seg_open ? ST_C_RD : ST_E_RD;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_M_RD: begin
        state_next = ST_M_CMP;
      end
      ST_M_CMP: begin
        if (stat.op_lt && stat.col_lt) begin
          cmd.push_old = 1'b1;
          cmd.op_inc   = 1'b1;
          state_next   = ST_M_RD;
        end else if (stat.op_lt && stat.col_eq) begin
          cmd.fadd_start = 1'b1;
          state_next     = ST_M_ADD;
        end else begin
          cmd.push_in = 1'b1;
          state_next  = ST_M_FIN;
        end
      end
      ST_M_ADD: begin
        if (stat.sum_done) begin
          cmd.push_sum = 1'b1;
          cmd.op_inc   = 1'b1;
          state_next   = ST_M_FIN;
        end
      end
      ST_M_FIN: begin
        state_next = stat.last ? ST_C_RD : ST_IDLE;
      end
      ST_C_RD: begin
        state_next = stat.op_lt ? ST_C_CMP : ST_SWAP;
      end
      ST_C_CMP: begin
        cmd.push_old = 1'b1;
        cmd.op_inc   = 1'b1;
        state_next   = ST_C_RD;
      end
      ST_SWAP: begin
        cmd.swap = 1'b1;
        unique case (stat.cmd)
          CMD_EMPTY:  state_next = ST_BEGIN;
          CMD_FINISH: state_next = ST_E_RD;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_BEGIN: begin
        state_next = (stat.row_open && stat.row_diff) ? ST_E_RD : ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply_begin = 1'b1;
        if (stat.cmd == CMD_ELEM) begin
          cmd.seg_set = 1'b1;
          state_next  = ST_M_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_E_RD: begin
        state_next = stat.op_lt ? ST_E_OUT : ST_E_END;
      end
      ST_E_OUT: begin
        if (stat.oslot) begin
          cmd.load_elem = 1'b1;
          cmd.op_inc    = 1'b1;
          state_next    = ST_E_RD;
        end
      end
      ST_E_END: begin
        if (stat.oslot) begin
          cmd.load_end   = 1'b1;
          cmd.emit_clear = 1'b1;
          state_next     = (stat.cmd == CMD_FINISH) ? ST_DONE : ST_APPLY;
        end
      end
      ST_DONE: begin
        if (stat.oslot) begin
          cmd.load_done = 1'b1;
          cmd.reset_all = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/srma_dp.sv =====
// Datapath for the sparse row merge accumulate unit: ping-pong row
// buffers, counters, input latch, adder and output register.
// Uses srma_pkg, srma_ram and srma_fadd.
module srma_dp #(
  parameter int ROW_CAP = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         cmd,
  input  logic [31:0]        row_id,
  input  logic [31:0]        col_id,
  input  logic [31:0]        value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [31:0]        out_col,
  output logic [31:0]        out_value,
  output logic               overflow,
  input  srma_pkg::dp_cmd_t  ctl,
  output srma_pkg::dp_stat_t stat
);
  import srma_pkg::*;

  localparam int CW = $clog2(ROW_CAP + 1);
  localparam int AW = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;

  // latched input item
  logic [1:0]  cmd_r;
  logic [31:0] row_r, col_r, val_r;
  logic        last_r;

  logic [CW-1:0] old_count, new_count, old_pointer;
  logic [31:0]   current_row;
  logic          row_open, overflow_seen, seg_open, sel;

  logic [63:0] rdata0, rdata1, rdata, wdata;
  logic        push, we0, we1, room;
  logic        sum_done;
  logic [31:0] sum;

  assign rdata = sel ? rdata1 : rdata0;
  assign push  = ctl.push_old | ctl.push_in | ctl.push_sum;
  assign room  = new_count < CW'(ROW_CAP);
  assign wdata = ctl.push_old ? rdata : {col_r, ctl.push_sum ? sum : val_r};
  // old row lives in bank sel, new row is written to the other bank
  assign we0   = push && room && sel;
  assign we1   = push && room && !sel;

  srma_ram #(.WIDTH(64), .DEPTH(ROW_CAP)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (new_count[AW-1:0]),
    .wdata (wdata),
    .raddr (old_pointer[AW-1:0]),
    .rdata (rdata0)
  );

  srma_ram #(.WIDTH(64), .DEPTH(ROW_CAP)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (new_count[AW-1:0]),
    .wdata (wdata),
    .raddr (old_pointer[AW-1:0]),
    .rdata (rdata1)
  );

  srma_fadd u_fadd (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.fadd_start),
    .a      (val_r),
    .b      (rdata[31:0]),
    .done   (sum_done),
    .result (sum)
  );

  // status toward the controller
  always_comb begin
    stat.cmd      = cmd_r;
    stat.last     = last_r;
    stat.seg_open = seg_open;
    stat.row_open = row_open;
    stat.row_diff = row_r != current_row;
    stat.op_lt    = old_pointer < old_count;
    stat.col_lt   = rdata[63:32] < col_r;
    stat.col_eq   = rdata[63:32] == col_r;
    stat.sum_done = sum_done;
    stat.oslot    = !out_valid || !out_stall;
  end

  // hold the accepted item
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_r  <= cmd;
      row_r  <= row_id;
      col_r  <= col_id;
      val_r  <= value;
      last_r <= last;
    end
  end

  // counters and row state
  always_ff @(posedge clk) begin
    if (rst || ctl.reset_all) begin
      old_count     <= '0;
      new_count     <= '0;
      old_pointer   <= '0;
      current_row   <= '0;
      row_open      <= 1'b0;
      overflow_seen <= 1'b0;
      seg_open      <= 1'b0;
      sel           <= 1'b0;
    end else begin
      if (push) begin
        if (room) begin
          new_count <= new_count + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (ctl.op_inc) begin
        old_pointer <= old_pointer + CW'(1);
      end
      if (ctl.swap) begin
        sel         <= !sel;
        old_count   <= new_count;
        new_count   <= '0;
        old_pointer <= '0;
        seg_open    <= 1'b0;
      end
      if (ctl.seg_set) begin
        seg_open    <= 1'b1;
        new_count   <= '0;
        old_pointer <= '0;
      end
      if (ctl.apply_begin) begin
        current_row <= row_r;
        row_open    <= 1'b1;
      end
      if (ctl.emit_clear) begin
        old_count     <= '0;
        old_pointer   <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  // output valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_elem || ctl.load_end || ctl.load_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (ctl.load_elem) begin
      kind      <= KIND_ELEM;
      out_col   <= rdata[63:32];
      out_value <= rdata[31:0];
      overflow  <= overflow_seen;
    end else if (ctl.load_end) begin
      kind      <= KIND_END;
      out_col   <= 32'd0;
      out_value <= 32'd0;
      overflow  <= overflow_seen;
    end else if (ctl.load_done) begin
      kind      <= KIND_DONE;
      out_col   <= 32'd0;
      out_value <= 32'd0;
      overflow  <= 1'b0;
    end
  end

endmodule

// ===== rtl/sparse_row_merge_accumulate_unit.sv =====
// Top level of the sparse row merge accumulate unit.
// Joins srma_ctrl and srma_dp; uses srma_pkg.
//
//  channel | signals                                    | direction
//  input   | in_valid, in_stall, cmd, row_id, col_id,   | item in
//          | value, last                                |
//  output  | out_valid, out_stall, kind, out_col,       | item out
//          | out_value, overflow                        |
//
// One item at a time: an element moves across each buffered entry with a
// smaller column and runs the adder when columns match; the first element
// of a segment first opens it, and closing a segment moves each remaining
// entry across. Emitting a row reads each result from the registered buffer
// before loading it into the output register.
// Reset is synchronous and clears all counters; the buffers are not cleared.
// An output stall holds the result register and pauses emission.
module sparse_row_merge_accumulate_unit #(
  parameter int ROW_CAP = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] row_id,
  input  logic [31:0] col_id,
  input  logic [31:0] value,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] out_col,
  output logic [31:0] out_value,
  output logic        overflow
);
  import srma_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  srma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (ctl)
  );

  srma_dp #(.ROW_CAP(ROW_CAP)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .row_id    (row_id),
    .col_id    (col_id),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_col   (out_col),
    .out_value (out_value),
    .overflow  (overflow),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

// ===== tb/sparse_row_merge_accumulate_unit_tb.sv =====
// Testbench for sparse_row_merge_accumulate_unit: drives segments, predicts each row
// with a local merge model and a binary32 adder, and checks every emitted item.
// Depends on srma_pkg and the RTL top level only.
`timescale 1ns / 100ps

module sparse_row_merge_accumulate_unit_tb;
  import srma_pkg::*;

  localparam int CAP = 32;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] col;
    logic [31:0] val;
    logic        ovf;
  } row_item_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [31:0] row_id;
  logic [31:0] col_id;
  logic [31:0] value;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [31:0] out_col;
  logic [31:0] out_value;
  logic        overflow;

  // merge state mirror
  logic [63:0] acc_row [CAP];
  logic [63:0] merge_row [CAP];
  int          acc_count;
  int          merge_count;
  int          acc_ptr;
  logic [31:0] open_row_id;
  bit          row_is_open;
  bit          row_lost;
  bit          seg_active;

  row_item_t   pending_items[$];
  int          err_count;
  int          cycle_count;
  bit          quiet;
  bit          hold_req;
  bit          hold_done;
  int          hold_count;
  int          stall_left;

  sparse_row_merge_accumulate_unit #(.ROW_CAP(CAP)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .row_id(row_id), .col_id(col_id), .value(value), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .out_col(out_col), .out_value(out_value), .overflow(overflow)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // binary32 add, round to nearest even, subnormals kept
  function automatic logic [31:0] fp32_sum(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    logic [7:0]  ea, eb;
    logic [26:0] xa, xb, tmp;
    logic [27:0] s;
    logic [24:0] m;
    logic        sa, sb, g, st;
    int          ex, d;
    ea = a[30:23];
    eb = b[30:23];
    if (ea == 8'hFF && a[22:0] != 0) return {a[31], 8'hFF, 1'b1, a[21:0]};
    if (eb == 8'hFF && b[22:0] != 0) return {b[31], 8'hFF, 1'b1, b[21:0]};
    if (ea == 8'hFF && eb == 8'hFF) return (a[31] != b[31]) ? QNAN_DEFAULT : a;
    if (ea == 8'hFF) return a;
    if (eb == 8'hFF) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    // keep the larger magnitude in a
    if (b[30:0] > a[30:0]) begin
      t = a;
      a = b;
      b = t;
    end
    ea = a[30:23];
    eb = b[30:23];
    sa = a[31];
    sb = b[31];
    xa = {(ea != 0), a[22:0], 3'b0};
    xb = {(eb != 0), b[22:0], 3'b0};
    ex = (ea == 0) ? 1 : ea;
    d = ex - ((eb == 0) ? 1 : eb);
    if (d >= 27) begin
      xb = {26'b0, (xb != 0)};
    end else if (d > 0) begin
      tmp = xb >> d;
      st = |(xb & ((27'd1 << d) - 27'd1));
      xb = tmp | {26'b0, st};
    end
    if (sa == sb) begin
      s = {1'b0, xa} + {1'b0, xb};
      if (s[27]) begin
        s = (s >> 1) | {27'b0, s[0]};
        ex++;
      end
    end else begin
      s = {1'b0, xa} - {1'b0, xb};
      if (s == 0) return 32'h0;
      while (!s[26] && ex > 1) begin
        s = s << 1;
        ex--;
      end
    end
    g = s[2];
    st = |s[1:0];
    m = {1'b0, s[26:3]};
    if (g && (st || m[0])) m = m + 25'd1;
    if (m[24]) begin
      m = m >> 1;
      ex++;
    end
    if (ex >= 255) return {sa, 8'hFF, 23'b0};
    return {sa, m[23] ? ex[7:0] : 8'd0, m[22:0]};
  endfunction

  task automatic expect_item(input logic [1:0] k, input logic [31:0] c,
                             input logic [31:0] v, input logic o);
    row_item_t e;
    e.kind = k;
    e.col = c;
    e.val = v;
    e.ovf = o;
    pending_items.push_back(e);
  endtask

  task automatic clear_merge_state();
    acc_count = 0;
    merge_count = 0;
    acc_ptr = 0;
    open_row_id = '0;
    row_is_open = 0;
    row_lost = 0;
    seg_active = 0;
  endtask

  task automatic push_merge(input logic [63:0] entry);
    if (merge_count < CAP) begin
      merge_row[merge_count] = entry;
      merge_count++;
    end else begin
      row_lost = 1;
    end
  endtask

  task automatic close_seg();
    while (acc_ptr < acc_count) begin
      push_merge(acc_row[acc_ptr]);
      acc_ptr++;
    end
    for (int i = 0; i < merge_count; i++) acc_row[i] = merge_row[i];
    acc_count = merge_count;
    merge_count = 0;
    acc_ptr = 0;
    seg_active = 0;
  endtask

  task automatic emit_acc_row();
    for (int i = 0; i < acc_count; i++)
      expect_item(KIND_ELEM, acc_row[i][63:32], acc_row[i][31:0], row_lost);
    expect_item(KIND_END, '0, '0, row_lost);
    acc_count = 0;
    acc_ptr = 0;
    row_lost = 0;
  endtask

  task automatic begin_seg(input logic [31:0] r);
    if (row_is_open && r != open_row_id) emit_acc_row();
    open_row_id = r;
    row_is_open = 1;
  endtask

  // advance the mirror by one accepted item
  task automatic predict_row_merge(input logic [1:0] c, input logic [31:0] r,
                                   input logic [31:0] col, input logic [31:0] v,
                                   input logic l);
    case (c)
      CMD_ELEM: begin
        if (!seg_active) begin
          begin_seg(r);
          seg_active = 1;
          merge_count = 0;
          acc_ptr = 0;
        end
        while (acc_ptr < acc_count && acc_row[acc_ptr][63:32] < col) begin
          push_merge(acc_row[acc_ptr]);
          acc_ptr++;
        end
        if (acc_ptr < acc_count && acc_row[acc_ptr][63:32] == col) begin
          push_merge({col, fp32_sum(v, acc_row[acc_ptr][31:0])});
          acc_ptr++;
        end else begin
          push_merge({col, v});
        end
        if (l) close_seg();
      end
      CMD_EMPTY: begin
        if (seg_active) close_seg();
        begin_seg(r);
      end
      CMD_FINISH: begin
        if (seg_active) close_seg();
        emit_acc_row();
        expect_item(KIND_DONE, '0, '0, 1'b0);
        clear_merge_state();
      end
      default: ;
    endcase
  endtask

  // offer one item; called and returns at a falling edge
  task automatic send_item(input logic [1:0] c, input logic [31:0] r,
                           input logic [31:0] col, input logic [31:0] v,
                           input logic l);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    row_id <= r;
    col_id <= col;
    value <= v;
    last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_row_merge(c, r, col, v, l);
    @(negedge clk);
  endtask

  // random binary32 pattern, no NaN; sometimes near 1.0 so sums cancel
  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 2) == 0) v[30:23] = 8'd120 + 8'($urandom_range(0, 15));
    if (v[30:23] == 8'hFF) v[22:0] = '0;
    return v;
  endfunction

  // one sorted segment of n elements over a small column pool
  task automatic send_segment(input logic [31:0] r, input int n, input int col_span);
    logic [31:0] col;
    col = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      send_item(CMD_ELEM, r, col, rand_value(), i == n - 1);
      col = col + 1 + $urandom_range(0, col_span);
    end
  endtask

  task automatic test_directed_basics();
    // first segment opens, same row merges, new row flushes
    send_item(CMD_ELEM, 32'd7, 32'd2, 32'h3F800000, 1'b0);
    send_item(CMD_ELEM, 32'd7, 32'd5, 32'h40000000, 1'b1);
    send_item(CMD_ELEM, 32'd7, 32'd2, 32'h3F800000, 1'b0);
    send_item(CMD_ELEM, 32'd7, 32'd3, 32'hBF800000, 1'b0);
    send_item(CMD_ELEM, 32'd7, 32'hFFFFFFFF, 32'h7FC00001, 1'b1);
    send_item(CMD_EMPTY, 32'hFFFFFFFF, '0, '0, 1'b0);
    // inf minus inf, signed zeros, subnormals, overflow to infinity
    send_item(CMD_ELEM, 32'hFFFFFFFF, 32'd0, 32'h7F800000, 1'b0);
    send_item(CMD_ELEM, 32'hFFFFFFFF, 32'd1, 32'h80000000, 1'b0);
    send_item(CMD_ELEM, 32'hFFFFFFFF, 32'd2, 32'h00000001, 1'b0);
    send_item(CMD_ELEM, 32'hFFFFFFFF, 32'd3, 32'h7F7FFFFF, 1'b1);
    send_item(CMD_ELEM, 32'hFFFFFFFF, 32'd0, 32'hFF800000, 1'b0);
    send_item(CMD_ELEM, 32'hFFFFFFFF, 32'd1, 32'h80000000, 1'b0);
    send_item(CMD_ELEM, 32'hFFFFFFFF, 32'd2, 32'h807FFFFF, 1'b0);
    send_item(CMD_ELEM, 32'hFFFFFFFF, 32'd3, 32'h7F7FFFFF, 1'b1);
    // ignored code, row id changing mid segment, unsorted, finish mid segment
    send_item(2'd3, 32'h5555AAAA, 32'hAAAA5555, 32'hFFFFFFFF, 1'b1);
    send_item(CMD_ELEM, 32'd9, 32'd9, 32'h3F800000, 1'b0);
    send_item(CMD_ELEM, 32'hAAAAAAAA, 32'd4, 32'h3F800000, 1'b0);
    send_item(CMD_FINISH, '0, '0, '0, 1'b0);
    send_item(CMD_FINISH, '0, '0, '0, 1'b0);
  endtask

  task automatic test_capacity_overflow();
    // one segment past capacity, then two segments whose union overflows
    for (int i = 0; i < CAP + 2; i++)
      send_item(CMD_ELEM, 32'd5, i, rand_value(), i == CAP + 1);
    send_item(CMD_EMPTY, 32'd6, '0, '0, 1'b0);
    for (int i = 0; i < 20; i++) send_item(CMD_ELEM, 32'd6, 2 * i, rand_value(), i == 19);
    for (int i = 0; i < 20; i++)
      send_item(CMD_ELEM, 32'd6, 2 * i + 1, rand_value(), i == 19);
    send_item(CMD_FINISH, '0, '0, '0, 1'b0);
  endtask

  task automatic test_backpressure();
    // output held off while input keeps coming
    hold_req = 1;
    send_segment(32'd11, 12, 1);
    send_segment(32'd12, 12, 1);
    send_segment(32'd13, 6, 1);
    send_item(CMD_EMPTY, 32'd14, '0, '0, 1'b0);
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int n;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      if (sent > n_items * 3 / 4) quiet = 1;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        n = $urandom_range(1, 6);
        send_segment($urandom_range(0, 3), n, $urandom_range(0, 3));
        sent += n;
      end else if (pick < 16) begin
        send_item(CMD_EMPTY, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3),
                  $urandom, $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick == 16) begin
        send_item(CMD_FINISH, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick == 17) begin
        send_item(2'd3, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        // broken segment: unsorted, full-range fields, maybe left open
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_item(CMD_ELEM, $urandom, $urandom, rand_value(), $urandom_range(0, 3) == 0);
        sent += n;
      end
    end
    send_item(CMD_FINISH, '0, '0, '0, 1'b0);
  endtask

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_items.size() == 0) begin
        $error("unexpected item: kind=%0d col=%h value=%h", kind, out_col, out_value);
        err_count++;
      end else begin
        row_item_t e;
        e = pending_items.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d, actual %0d", e.kind, kind);
          err_count++;
        end
        if (out_col !== e.col) begin
          $error("out_col: expected %h, actual %h", e.col, out_col);
          err_count++;
        end
        if (out_value !== e.val) begin
          $error("out_value: expected %h, actual %h", e.val, out_value);
          err_count++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow: expected %0d, actual %0d", e.ovf, overflow);
          err_count++;
        end
      end
    end
  end

  // output stall: long hold-off once requested, else random bursts
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    hold_count = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_count = 500;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 15);
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sparse_row_merge_accumulate_unit");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_ELEM;
    row_id = '0;
    col_id = '0;
    value = '0;
    last = 1'b0;
    quiet = 0;
    clear_merge_state();
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_directed_basics();
    test_capacity_overflow();
    test_backpressure();
    test_random(140);
    in_valid <= 1'b0;
    while (pending_items.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (err_count == 0) begin
      $display("PASS sparse_row_merge_accumulate_unit");
    end else begin
      $display("FAIL sparse_row_merge_accumulate_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/srma_pkg.sv
rtl/srma_ram.sv
rtl/srma_fadd.sv
rtl/srma_ctrl.sv
rtl/srma_dp.sv
rtl/sparse_row_merge_accumulate_unit.sv
tb/sparse_row_merge_accumulate_unit_tb.sv
